[hw/rtl/fsnt_pkg.sv]
// Shared types, constants and name helpers for the fixed-slot name table.
package fsnt_pkg;

	localparam int SLOTS      = 64;
	localparam int NAME_BYTES = 8;
	localparam int NAME_W     = 8 * NAME_BYTES;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int LEN_W      = 4;
	localparam int REQ_W      = 3;
	localparam int CFG_W      = 7;

	localparam logic [REQ_W-1:0] REQ_PUT      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REM_IDX  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REM_NAME = 3'd4;

	localparam logic CFG_NAME_LENGTH = 1'b0;
	localparam logic CFG_SLOT_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_STAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [NAME_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic              vld;
		logic              stat;
		logic [SLOT_W-1:0] idx;
	} rd_tag_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot;
		logic [NAME_W-1:0] name;
		logic [SLOT_W-1:0] used;
		logic [SLOT_W-1:0] last;
		logic [LEN_W-1:0]  longest;
		logic              full;
		logic              empty;
	} result_t;

	// Keep bytes up to the first zero byte, at most lim bytes.
	function automatic logic [NAME_W-1:0] name_view(input logic [NAME_W-1:0] x,
		input logic [LEN_W-1:0] lim);
		logic [NAME_W-1:0] r;
		logic              live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (x[8*i +: 8] == 8'h00 || LEN_W'(i) >= lim) live = 1'b0;
			if (live) r[8*i +: 8] = x[8*i +: 8];
		end
		return r;
	endfunction

	// Count leading nonzero bytes.
	function automatic logic [LEN_W-1:0] name_len(input logic [NAME_W-1:0] x);
		logic [LEN_W-1:0] n;
		logic             live;
		n    = '0;
		live = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (x[8*i +: 8] == 8'h00) live = 1'b0;
			if (live) n = n + LEN_W'(1);
		end
		return n;
	endfunction

endpackage

[hw/rtl/fsnt_store.sv]
// Name store: single-port-read, single-port-write memory with per-slot valid bits.
module fsnt_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fsnt_pkg::mem_req_t         mem_req,
	output logic [fsnt_pkg::NAME_W-1:0] rd_data
);

	logic [fsnt_pkg::NAME_W-1:0] store_q [fsnt_pkg::SLOTS];
	logic [fsnt_pkg::SLOTS-1:0]  valid_q;
	logic [fsnt_pkg::NAME_W-1:0] rd_word_s1;
	logic                        rd_hit_s1;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) store_q[mem_req.wr_addr] <= mem_req.wr_data;
		if (mem_req.rd_en) rd_word_s1 <= store_q[mem_req.rd_addr];
	end

	// A slot never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_hit_s1 <= 1'b0;
		end else begin
			if (mem_req.wr_en) valid_q[mem_req.wr_addr] <= 1'b1;
			if (mem_req.rd_en) rd_hit_s1 <= valid_q[mem_req.rd_addr];
		end
	end

	assign rd_data = rd_hit_s1 ? rd_word_s1 : '0;

endmodule

[hw/rtl/fsnt_ctrl.sv]
// Sequencer: operation scan, write-back and status scan over the name store.
module fsnt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fsnt_pkg::REQ_W-1:0]  req_type,
	input  logic [fsnt_pkg::SLOT_W-1:0] slot_in,
	input  logic [fsnt_pkg::NAME_W-1:0] name_in,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [fsnt_pkg::CFG_W-1:0]  cfg_data,
	output fsnt_pkg::mem_req_t          mem_req,
	input  logic [fsnt_pkg::NAME_W-1:0] rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output fsnt_pkg::result_t           res
);

	fsnt_pkg::state_t state_q, state_d;

	logic [fsnt_pkg::LEN_W-1:0]  name_length_q;
	logic [fsnt_pkg::CNT_W-1:0]  slot_count_q;

	logic [fsnt_pkg::SLOT_W-1:0] ptr_q;
	logic                        issue_q;
	fsnt_pkg::rd_tag_t           tag_s1;

	logic [fsnt_pkg::REQ_W-1:0]  req_q;
	logic [fsnt_pkg::SLOT_W-1:0] end_q;
	logic [fsnt_pkg::SLOT_W-1:0] last_idx_q;
	logic [fsnt_pkg::LEN_W-1:0]  lim_q;
	logic [fsnt_pkg::NAME_W-1:0] key_q;
	logic [fsnt_pkg::NAME_W-1:0] put_val_q;

	logic                        ok_q;
	logic [fsnt_pkg::SLOT_W-1:0] slot_q;
	logic [fsnt_pkg::NAME_W-1:0] name_q;
	logic [fsnt_pkg::CNT_W-1:0]  used_q;
	logic [fsnt_pkg::SLOT_W-1:0] last_q;
	logic [fsnt_pkg::LEN_W-1:0]  longest_q;
	logic                        full_q;
	logic                        empty_q;

	logic [fsnt_pkg::LEN_W-1:0]  eff_len;
	logic [fsnt_pkg::SLOT_W-1:0] eff_last;
	logic                        accept;
	logic                        idx_req;
	logic                        go_op;
	logic [fsnt_pkg::SLOT_W-1:0] start_ptr;
	logic                        op_data;
	logic                        st_data;
	logic                        hit;
	logic                        op_last;
	logic [fsnt_pkg::NAME_W-1:0] rd_view;
	logic [fsnt_pkg::LEN_W-1:0]  rd_len;
	logic [fsnt_pkg::SLOT_W-1:0] scan_end;
	logic                        writes;

	// Clamp the configuration to its usable range.
	always_comb begin
		if (name_length_q < fsnt_pkg::LEN_W'(2)) eff_len = fsnt_pkg::LEN_W'(2);
		else if (name_length_q > fsnt_pkg::LEN_W'(fsnt_pkg::NAME_BYTES))
			eff_len = fsnt_pkg::LEN_W'(fsnt_pkg::NAME_BYTES);
		else eff_len = name_length_q;

		if (slot_count_q < fsnt_pkg::CNT_W'(2)) eff_last = fsnt_pkg::SLOT_W'(1);
		else if (slot_count_q > fsnt_pkg::CNT_W'(fsnt_pkg::SLOTS))
			eff_last = fsnt_pkg::SLOT_W'(fsnt_pkg::SLOTS - 1);
		else eff_last = fsnt_pkg::SLOT_W'(slot_count_q - fsnt_pkg::CNT_W'(1));
	end

	assign accept  = in_valid && (state_q == fsnt_pkg::ST_IDLE);
	assign idx_req = (req_type == fsnt_pkg::REQ_READ) || (req_type == fsnt_pkg::REQ_REM_IDX);

	always_comb begin
		go_op     = 1'b0;
		start_ptr = '0;
		if (req_type == fsnt_pkg::REQ_PUT) begin
			go_op     = 1'b1;
			start_ptr = fsnt_pkg::SLOT_W'(1);
		end else if (idx_req) begin
			go_op     = (slot_in <= eff_last);
			start_ptr = slot_in;
		end else if (req_type == fsnt_pkg::REQ_SEARCH || req_type == fsnt_pkg::REQ_REM_NAME) begin
			go_op = 1'b1;
		end
	end

	assign rd_view = fsnt_pkg::name_view(rd_data, lim_q);
	assign rd_len  = fsnt_pkg::name_len(rd_view);
	assign op_data = tag_s1.vld && !tag_s1.stat && (state_q == fsnt_pkg::ST_OP);
	assign st_data = tag_s1.vld && tag_s1.stat && (state_q == fsnt_pkg::ST_STAT);
	assign op_last = (tag_s1.idx == end_q);

	always_comb begin
		unique case (req_q)
			fsnt_pkg::REQ_PUT:      hit = (rd_data[7:0] == 8'h00);
			fsnt_pkg::REQ_READ:     hit = 1'b1;
			fsnt_pkg::REQ_REM_IDX:  hit = 1'b1;
			fsnt_pkg::REQ_SEARCH:   hit = (rd_view == key_q);
			fsnt_pkg::REQ_REM_NAME: hit = (rd_view == key_q);
			default:                hit = 1'b0;
		endcase
	end

	assign writes = (req_q == fsnt_pkg::REQ_PUT) || (req_q == fsnt_pkg::REQ_REM_IDX) ||
		(req_q == fsnt_pkg::REQ_REM_NAME);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsnt_pkg::ST_IDLE: if (accept) state_d = go_op ? fsnt_pkg::ST_OP : fsnt_pkg::ST_STAT;
			fsnt_pkg::ST_OP:   if (op_data && (hit || op_last)) state_d = fsnt_pkg::ST_STAT;
			fsnt_pkg::ST_STAT: if (st_data && tag_s1.idx == last_idx_q) state_d = fsnt_pkg::ST_DONE;
			fsnt_pkg::ST_DONE: if (res_ready) state_d = fsnt_pkg::ST_IDLE;
			default:           state_d = fsnt_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall        = (state_q != fsnt_pkg::ST_IDLE);
		res_valid       = (state_q == fsnt_pkg::ST_DONE);
		mem_req.rd_en   = issue_q &&
			(state_q == fsnt_pkg::ST_OP || state_q == fsnt_pkg::ST_STAT);
		mem_req.rd_addr = ptr_q;
		mem_req.wr_en   = op_data && hit && writes;
		mem_req.wr_addr = tag_s1.idx;
		mem_req.wr_data = (req_q == fsnt_pkg::REQ_PUT) ? put_val_q : '0;
		scan_end        = (state_q == fsnt_pkg::ST_OP) ? end_q : last_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fsnt_pkg::ST_IDLE;
			name_length_q <= fsnt_pkg::LEN_W'(8);
			slot_count_q  <= fsnt_pkg::CNT_W'(64);
			ptr_q         <= '0;
			issue_q       <= 1'b0;
			tag_s1        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == fsnt_pkg::CFG_NAME_LENGTH)
					name_length_q <= cfg_data[fsnt_pkg::LEN_W-1:0];
				else
					slot_count_q <= cfg_data[fsnt_pkg::CNT_W-1:0];
			end
			tag_s1.vld  <= mem_req.rd_en;
			tag_s1.stat <= (state_q == fsnt_pkg::ST_STAT);
			tag_s1.idx  <= ptr_q;
			// Restart the read pointer for each scan; stop issuing at the scan end.
			if (accept) begin
				ptr_q   <= go_op ? start_ptr : '0;
				issue_q <= 1'b1;
			end else if (state_q == fsnt_pkg::ST_OP && state_d == fsnt_pkg::ST_STAT) begin
				ptr_q   <= '0;
				issue_q <= 1'b1;
			end else if (mem_req.rd_en) begin
				if (ptr_q == scan_end) issue_q <= 1'b0;
				else ptr_q <= ptr_q + fsnt_pkg::SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req_type;
			end_q      <= idx_req ? slot_in : eff_last;
			last_idx_q <= eff_last;
			lim_q      <= eff_len - fsnt_pkg::LEN_W'(1);
			key_q      <= fsnt_pkg::name_view(name_in, eff_len);
			put_val_q  <= fsnt_pkg::name_view(name_in, eff_len - fsnt_pkg::LEN_W'(1));
			ok_q       <= 1'b0;
			slot_q     <= '0;
			name_q     <= '0;
			used_q     <= '0;
			last_q     <= '0;
			longest_q  <= '0;
			full_q     <= 1'b1;
			empty_q    <= 1'b1;
		end else begin
			if (op_data && hit) begin
				ok_q   <= 1'b1;
				slot_q <= tag_s1.idx;
				if (req_q == fsnt_pkg::REQ_READ) name_q <= rd_view;
			end
			if (st_data) begin
				if (rd_len > longest_q) longest_q <= rd_len;
				if (rd_view[7:0] != 8'h00) begin
					used_q  <= used_q + fsnt_pkg::CNT_W'(1);
					last_q  <= tag_s1.idx;
					empty_q <= 1'b0;
				end else if (tag_s1.idx != '0) begin
					full_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		res.ok      = ok_q;
		res.slot    = slot_q;
		res.name    = name_q;
		res.used    = used_q[fsnt_pkg::SLOT_W-1:0];
		res.last    = last_q;
		res.longest = longest_q + fsnt_pkg::LEN_W'(1);
		res.full    = full_q;
		res.empty   = empty_q;
	end

endmodule

[hw/rtl/fixed_slot_name_table.sv]
// Fixed-slot name table: top level with handshake and result register.
//
// Usage
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   req_type, slot_in and name_in. Output channel (out_valid / out_stall)
//   carries one result per request, with the operation outcome and the
//   table status after the operation.
//   Configuration (cfg_we, cfg_index, cfg_data) sets name_length (index 0)
//   and slot_count (index 1); write only while the table is idle.
// Request processing
//   One request is worked on at a time. The single read port of the name
//   store sets the rate: an operation scan of k reads (k = 1 for in-range
//   index requests, up to slot_count for put, search and remove by name),
//   then a status scan of slot_count reads.
// Reset
//   arst_n clears all slots (through per-slot valid bits, no clearing
//   pass), resets name_length to 8 and slot_count to 64.
// Stall
//   A finished result waits in the output register while out_stall is
//   high; the next request is taken meanwhile, and its result holds inside
//   the sequencer until the output register frees up.
module fixed_slot_name_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fsnt_pkg::REQ_W-1:0]  req_type,
	input  logic [fsnt_pkg::SLOT_W-1:0] slot_in,
	input  logic [fsnt_pkg::NAME_W-1:0] name_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [fsnt_pkg::SLOT_W-1:0] slot_out,
	output logic [fsnt_pkg::NAME_W-1:0] name_out,
	output logic [fsnt_pkg::SLOT_W-1:0] used_count,
	output logic [fsnt_pkg::SLOT_W-1:0] last_used,
	output logic [fsnt_pkg::LEN_W-1:0]  longest_len,
	output logic                        is_full,
	output logic                        is_empty,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [fsnt_pkg::CFG_W-1:0]  cfg_data
);

	fsnt_pkg::mem_req_t          mem_req;
	logic [fsnt_pkg::NAME_W-1:0] rd_data;
	logic                        res_valid;
	logic                        res_ready;
	fsnt_pkg::result_t           res;
	fsnt_pkg::result_t           out_q;
	logic                        out_valid_q;

	fsnt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	fsnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.slot_in   (slot_in),
		.name_in   (name_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Load the output register when it is empty or being drained this cycle.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Hold the payload while stalled.
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_q.ok;
	assign slot_out    = out_q.slot;
	assign name_out    = out_q.name;
	assign used_count  = out_q.used;
	assign last_used   = out_q.last;
	assign longest_len = out_q.longest;
	assign is_full     = out_q.full;
	assign is_empty    = out_q.empty;

endmodule

[hw/rtl/fsnt_checker.sv]
// Port-level checker for the fixed-slot name table, bound to the top level.
module fsnt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        ok,
	input logic [fsnt_pkg::SLOT_W-1:0] slot_out,
	input logic [fsnt_pkg::NAME_W-1:0] name_out,
	input logic [fsnt_pkg::SLOT_W-1:0] used_count,
	input logic [fsnt_pkg::SLOT_W-1:0] last_used,
	input logic                        is_empty
);

	// A result waiting under stall stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// One request at a time: busy right after a transfer in.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	// A failed operation reports no slot and no name.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> (slot_out == '0) && (name_out == '0))
		else $error("failed operation reports slot or name");

	// Empty flag agrees with the used count and last used slot.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (used_count == '0)) &&
			(!is_empty || last_used == '0))
		else $error("empty status inconsistent");

endmodule

bind fixed_slot_name_table fsnt_checker u_fsnt_checker (.*);
